/* src/satl_pkg.sv */
// Shared constants, types and the controller state encoding for the
// set-associative tag lookup. No dependencies.
package satl_pkg;

	// Address layout: 32-bit byte address, 64-byte lines
	localparam int ADDR_W     = 32;
	localparam int LINE_OFF_W = 6;
	localparam int LINE_W     = ADDR_W - LINE_OFF_W;
	localparam int SIZE_W     = 12;
	localparam int IN_DATA_W  = 48;

	// Span of one access: line offset plus length, and the touched-line count
	localparam int SPAN_W  = 13;
	localparam int COUNT_W = 6;

	// Widest way index the block supports
	localparam int MAX_WAY_W = 4;

	// Outcome of one set lookup
	typedef struct packed {
		logic                 hit;
		logic [MAX_WAY_W-1:0] way;
	} lookup_res_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

endpackage

/* src/satl_tag_ram.sv */
// Tag RAM: one row per set, one write port and one registered read port.
// Depends on nothing.
module satl_tag_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 170,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one row
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one row, data valid the next cycle and held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/satl_way_sel.sv */
// Way compare and FIFO replacement for one set row; produces the updated row.
// Depends on satl_pkg.
module satl_way_sel #(
	parameter int WAYS   = 8,
	parameter int TAG_W  = 20,
	parameter int WAY_W  = 3,
	parameter int FILL_W = 4,
	parameter int ROW_W  = 167
) (
	input  logic [ROW_W-1:0]        row_in,
	input  logic [TAG_W-1:0]        tag,
	output logic [ROW_W-1:0]        row_out,
	output satl_pkg::lookup_res_t   res
);
	import satl_pkg::*;

	localparam int TAGS_W = WAYS * TAG_W;

	logic [WAYS-1:0][TAG_W-1:0] tags;
	logic [WAYS-1:0][TAG_W-1:0] new_tags;
	logic [WAY_W-1:0]           vic;
	logic [WAY_W-1:0]           new_vic;
	logic [FILL_W-1:0]          fill;
	logic [FILL_W-1:0]          new_fill;
	logic                       hit;
	logic [WAY_W-1:0]           hit_way;
	logic [WAY_W-1:0]           way;

	// Unpack the row: {fill, victim pointer, tags}
	assign tags = row_in[TAGS_W-1:0];
	assign vic  = row_in[TAGS_W +: WAY_W];
	assign fill = row_in[TAGS_W+WAY_W +: FILL_W];

	// Compare only filled ways; lowest matching way wins
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (FILL_W'(w) < fill && tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	// Pick the way on a miss: next empty one, else the FIFO victim
	always_comb begin
		new_fill = fill;
		new_vic  = vic;
		new_tags = tags;
		way      = hit_way;
		if (!hit) begin
			if (fill < FILL_W'(WAYS)) begin
				way      = WAY_W'(fill);
				new_fill = fill + FILL_W'(1);
			end else begin
				way     = vic;
				new_vic = (vic == WAY_W'(WAYS - 1)) ? '0 : vic + WAY_W'(1);
			end
			new_tags[way] = tag;
		end
	end

	assign row_out = {new_fill, new_vic, new_tags};
	assign res.hit = hit;
	assign res.way = MAX_WAY_W'(way);

endmodule

/* src/set_assoc_cache_tag_lookup.sv */
// Set-associative tag lookup with FIFO replacement. An access of n touched
// lines is taken in the idle state and then gives one result per cycle while
// the output register is free; each line is a read-modify-write of one tag
// RAM row through the single-port-pair tag RAM. A new access is taken once
// the previous one has issued its last result; the output register lets that
// result wait while the next access is already taken. After reset a clearing
// pass zeroes the per-set fill counts and victim pointers, during which no
// access is taken. SETS must be a power of two. Lines are 64 bytes.
// Depends on satl_pkg, satl_tag_ram and satl_way_sel.
module set_assoc_cache_tag_lookup #(
	parameter int SETS      = 64,
	parameter int WAYS      = 8,
	parameter int MAX_BYTES = 2048
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] address, [43:32] size_bytes, [47:44] zero
	input  logic [satl_pkg::IN_DATA_W-1:0] s_tdata,

	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] hit, [26:1] line_address, then set_number, then way_number, zero fill
	output logic [((1 + satl_pkg::LINE_W + $clog2(SETS)
		+ ((WAYS > 1) ? $clog2(WAYS) : 1) + 7) / 8) * 8 - 1:0] m_tdata,
	output logic                           m_tlast
);
	import satl_pkg::*;

	localparam int SET_W      = $clog2(SETS);
	localparam int TAG_W      = LINE_W - SET_W;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FILL_W     = $clog2(WAYS + 1);
	localparam int ROW_W      = FILL_W + WAY_W + WAYS * TAG_W;
	localparam int OUT_DATA_W = ((1 + LINE_W + SET_W + WAY_W + 7) / 8) * 8;

	state_t             st_q;
	state_t             st_d;
	logic [SET_W-1:0]   clr_q;
	logic [LINE_W-1:0]  line_q;
	logic [COUNT_W-1:0] remain_q;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [LINE_W-1:0]  out_line_q;
	logic [SET_W-1:0]   out_set_q;
	logic [WAY_W-1:0]   out_way_q;
	logic               out_last_q;

	logic [ADDR_W-1:0]  in_addr;
	logic [SIZE_W-1:0]  in_size;
	logic [SIZE_W-1:0]  size_sat;
	logic [SPAN_W-1:0]  span;
	logic [COUNT_W-1:0] in_count;

	logic               out_free;
	logic               advance;
	logic               is_last;
	logic [LINE_W-1:0]  next_line;
	logic               mem_we;
	logic [SET_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;
	logic               mem_re;
	logic [SET_W-1:0]   mem_raddr;
	logic [ROW_W-1:0]   mem_rdata;
	logic [ROW_W-1:0]   new_row;
	lookup_res_t        res;

	// Decode the access and count its lines
	assign in_addr = s_tdata[ADDR_W-1:0];
	assign in_size = s_tdata[ADDR_W +: SIZE_W];

	always_comb begin
		size_sat = in_size;
		if (in_size == '0) begin
			size_sat = SIZE_W'(1);
		end else if (in_size > SIZE_W'(MAX_BYTES)) begin
			size_sat = SIZE_W'(MAX_BYTES);
		end
	end

	assign span     = SPAN_W'(in_addr[LINE_OFF_W-1:0]) + SPAN_W'(size_sat) - SPAN_W'(1);
	assign in_count = COUNT_W'(span >> LINE_OFF_W) + COUNT_W'(1);

	// Line bookkeeping
	assign out_free  = !out_valid_q || m_tready;
	assign is_last   = (remain_q == COUNT_W'(1));
	assign next_line = line_q + LINE_W'(1);

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (clr_q == SET_W'(SETS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					st_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (out_free && is_last) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_CLEAR;
		endcase
	end

	// Controller outputs and RAM port control
	always_comb begin
		s_tready  = 1'b0;
		advance   = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = line_q[SET_W-1:0];
		mem_wdata = new_row;
		mem_re    = 1'b0;
		mem_raddr = next_line[SET_W-1:0];
		case (st_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				mem_re    = s_tvalid;
				mem_raddr = in_addr[LINE_OFF_W +: SET_W];
			end
			ST_LOOK: begin
				advance = out_free;
				mem_we  = out_free;
				mem_re  = out_free && !is_last;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// State, clear counter and line walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			clr_q    <= '0;
			line_q   <= '0;
			remain_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (s_tvalid && s_tready) begin
				line_q   <= in_addr[ADDR_W-1:LINE_OFF_W];
				remain_q <= in_count;
			end else if (advance) begin
				line_q   <= next_line;
				remain_q <= remain_q - COUNT_W'(1);
			end
		end
	end

	satl_tag_ram #(
		.DEPTH (SETS),
		.WIDTH (ROW_W),
		.AW    (SET_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	satl_way_sel #(
		.WAYS   (WAYS),
		.TAG_W  (TAG_W),
		.WAY_W  (WAY_W),
		.FILL_W (FILL_W),
		.ROW_W  (ROW_W)
	) u_way_sel (
		.row_in  (mem_rdata),
		.tag     (line_q[LINE_W-1:SET_W]),
		.row_out (new_row),
		.res     (res)
	);

	// Output register: load a result on advance, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_hit_q  <= res.hit;
			out_line_q <= line_q;
			out_set_q  <= line_q[SET_W-1:0];
			out_way_q  <= res.way[WAY_W-1:0];
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_way_q, out_set_q, out_line_q, out_hit_q});
	assign m_tlast  = out_last_q;

	// The tag RAM is never written between accesses
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !mem_we)
		else $error("tag RAM written while idle");

	// A hit leaves the set row untouched
	a_hit_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.hit |-> new_row == mem_rdata)
		else $error("hit modified the set row");

	// The final line of an access returns the controller to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_last |=> st_q == ST_IDLE)
		else $error("access did not end after its last line");

endmodule

/* verif/tb_set_assoc_cache_tag_lookup.sv */
// Self-checking testbench for set_assoc_cache_tag_lookup: streams accesses into
// the tag lookup and checks every per-line hit/fill result against a predictor.
// Depends on satl_pkg and the set_assoc_cache_tag_lookup RTL.
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lookup;

	import satl_pkg::*;

	localparam int SETS       = 64;
	localparam int WAYS       = 8;
	localparam int MAX_BYTES  = 2048;
	localparam int LINE_BYTES = 64;
	localparam int SET_W      = 6;
	localparam int WAY_W      = 3;
	localparam int TAG_W      = LINE_W - SET_W;
	localparam int OUT_W      = ((1 + LINE_W + SET_W + WAY_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		bit                drain;
	} access_t;

	typedef struct {
		logic             hit;
		logic [LINE_W-1:0] line_addr;
		logic [SET_W-1:0] set_idx;
		logic [WAY_W-1:0] way;
		logic             last;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// [31:0] address, [43:32] size_bytes, [47:44] zero
	logic [IN_DATA_W-1:0] s_tdata = '0;

	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [0] hit, [26:1] line_address, [32:27] set_number, [35:33] way_number, zero fill
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;

	// Predictor state: tags, fill counts and FIFO victim pointers per set
	logic [TAG_W-1:0] tag_of [SETS][WAYS];
	logic [3:0]       ways_filled [SETS];
	logic [WAY_W-1:0] next_victim [SETS];

	access_t      pending_accesses[$];
	line_result_t expected_lines[$];
	int           items_sent = 0;
	int           errors = 0;
	int           cycles = 0;
	bit           quiet;

	set_assoc_cache_tag_lookup #(
		.SETS(SETS),
		.WAYS(WAYS),
		.MAX_BYTES(MAX_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// Clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Drop all idling on both sides through a stretch of the run
	assign quiet = (items_sent >= 45) && (items_sent < 75);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Look up one line; on a miss fill the next empty way or replace the oldest
	function automatic void probe_set(input logic [LINE_W-1:0] line,
			output logic hit, output logic [WAY_W-1:0] way);
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		int               filled;
		set_idx = line[SET_W-1:0];
		tag     = line[LINE_W-1:SET_W];
		filled  = ways_filled[set_idx];
		hit     = 1'b0;
		way     = '0;
		for (int w = 0; w < filled; w++) begin
			if (!hit && tag_of[set_idx][w] == tag) begin
				hit = 1'b1;
				way = w[WAY_W-1:0];
			end
		end
		if (!hit) begin
			if (filled < WAYS) begin
				way = filled[WAY_W-1:0];
				ways_filled[set_idx] = 4'(filled + 1);
			end else begin
				way = next_victim[set_idx];
				next_victim[set_idx] = way + 1'b1;
			end
			tag_of[set_idx][way] = tag;
		end
	endfunction

	// Expand one access into its touched lines and queue their results
	task automatic predict_access(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size_in);
		int            len;
		int            count;
		logic [LINE_W-1:0] line;
		line_result_t  r;
		len = (size_in == 0) ? 1 : int'(size_in);
		if (len > MAX_BYTES)
			len = MAX_BYTES;
		count = (int'(addr[LINE_OFF_W-1:0]) + len - 1) / LINE_BYTES + 1;
		for (int k = 0; k < count; k++) begin
			line = addr[ADDR_W-1:LINE_OFF_W] + LINE_W'(k);
			probe_set(line, r.hit, r.way);
			r.line_addr = line;
			r.set_idx   = line[SET_W-1:0];
			r.last      = (k == count - 1);
			expected_lines.insert(expected_lines.size(), r);
		end
	endtask

	function automatic void add_access(input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input bit drain);
		access_t a;
		a.addr  = addr;
		a.size  = size;
		a.drain = drain;
		pending_accesses.insert(pending_accesses.size(), a);
	endfunction

	// Driver: present queued accesses, predict each one on its transfer
	always @(posedge clk or negedge arst_n) begin : drive
		access_t acc;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_access(s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: SIZE_W]);
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_accesses.size() != 0
						&& !(pending_accesses[0].drain && expected_lines.size() != 0)
						&& (quiet || $urandom_range(99) >= 35)) begin
					acc = pending_accesses.pop_front();
					s_tdata  <= {{(IN_DATA_W - ADDR_W - SIZE_W){1'b0}}, acc.size, acc.addr};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each result transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : monitor
		line_result_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_lines.size() == 0) begin
					report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
						m_tdata, m_tlast));
				end else begin
					e = expected_lines.pop_front();
					if (m_tdata[0] !== e.hit)
						report_mismatch($sformatf("line %h: hit %b, want %b",
							e.line_addr, m_tdata[0], e.hit));
					if (m_tdata[LINE_W:1] !== e.line_addr)
						report_mismatch($sformatf("line_address %h, want %h",
							m_tdata[LINE_W:1], e.line_addr));
					if (m_tdata[LINE_W+1 +: SET_W] !== e.set_idx)
						report_mismatch($sformatf("line %h: set %0d, want %0d",
							e.line_addr, m_tdata[LINE_W+1 +: SET_W], e.set_idx));
					if (m_tdata[LINE_W+1+SET_W +: WAY_W] !== e.way)
						report_mismatch($sformatf("line %h: way %0d, want %0d",
							e.line_addr, m_tdata[LINE_W+1+SET_W +: WAY_W], e.way));
					if (m_tlast !== e.last)
						report_mismatch($sformatf("line %h: last %b, want %b",
							e.line_addr, m_tlast, e.last));
				end
			end
			m_tready <= quiet || ($urandom_range(99) >= 35);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		int                pick;
		for (int s = 0; s < SETS; s++) begin
			ways_filled[s] = '0;
			next_victim[s] = '0;
		end

		// Single line, repeat hit, two-line straddle, zero length
		add_access(32'h0000_0000, 12'd1, 1'b0);
		add_access(32'h0000_0000, 12'd1, 1'b0);
		add_access(32'h0000_003F, 12'd2, 1'b0);
		add_access(32'h0000_0000, 12'd0, 1'b0);
		// Oversized length saturates; unaligned maximum touches 33 lines
		add_access(32'h0000_0040, 12'hFFF, 1'b0);
		add_access(32'h0000_0020, 12'd2048, 1'b0);
		// Wrap past the top of the address space
		add_access(32'hFFFF_FFFF, 12'd2, 1'b0);
		add_access(32'hFFFF_FFC0, 12'd2048, 1'b0);
		// Fill set 5 beyond its ways to force FIFO replacement
		for (int t = 1; t <= 10; t++)
			add_access(32'(t * 4096 + 5 * 64), 12'd1, 1'b0);
		add_access(32'(1 * 4096 + 5 * 64), 12'd1, 1'b0);
		add_access(32'(10 * 4096 + 5 * 64), 12'd1, 1'b0);
		// Exact single line and the same length one byte off
		add_access(32'h0000_1000, 12'd64, 1'b0);
		add_access(32'h0000_1001, 12'd64, 1'b0);

		// Random accesses: mostly a small tag pool over a few sets
		for (int i = 0; i < 88; i++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				addr = {20'($urandom_range(11)), 6'($urandom_range(7)), 6'($urandom_range(63))};
			else
				addr = $urandom;
			pick = $urandom_range(99);
			if (pick < 70)
				size = 12'($urandom_range(130, 1));
			else if (pick < 75)
				size = '0;
			else if (pick < 90)
				size = 12'($urandom_range(2048, 131));
			else
				size = 12'($urandom_range(4095, 2049));
			add_access(addr, size, (i == 0) || (i == 70));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_accesses.size() == 0 && !s_tvalid && expected_lines.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
